@@ hdl/ffcr_pkg.sv @@
// shared types and constants of the fixed frame command receiver
package ffcr_pkg;

	localparam int unsigned FrameLen = 14;
	localparam int unsigned StoreLen = FrameLen - 1;
	localparam int unsigned CountW   = $clog2(FrameLen);
	localparam int unsigned WordW    = 32;

	localparam logic [7:0] ByteStart = 8'd2;
	localparam logic [7:0] ByteEnd   = 8'd3;

	localparam logic [7:0] InstrWaypoint  = 8'd10;
	localparam logic [7:0] InstrStart     = 8'd11;
	localparam logic [7:0] InstrPause     = 8'd12;
	localparam logic [7:0] InstrStop      = 8'd13;
	localparam logic [7:0] InstrTelemetry = 8'd14;

	typedef enum logic [2:0] {
		EV_WAYPOINT  = 3'd0,
		EV_START     = 3'd1,
		EV_PAUSE     = 3'd2,
		EV_STOP      = 3'd3,
		EV_TELEMETRY = 3'd4,
		EV_REJECT    = 3'd5
	} event_t;

	typedef struct packed {
		logic             done;
		logic             ok;
		logic [7:0]       instr;
		logic [WordW-1:0] x;
		logic [WordW-1:0] y;
		logic [WordW-1:0] z;
	} frame_t;

	typedef struct packed {
		event_t           ev;
		logic [WordW-1:0] x;
		logic [WordW-1:0] y;
		logic [WordW-1:0] z;
		logic             paused;
	} result_t;

endpackage

@@ hdl/ffcr_channels.sv @@
// valid/ready channel interfaces for received bytes and decoded events
interface ffcr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       parity_error;

	modport source (output valid, output rx_byte, output parity_error, input ready);
	modport sink (input valid, input rx_byte, input parity_error, output ready);
endinterface

interface ffcr_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;
	logic        paused;

	modport source (output valid, output event_res, output coord_x, output coord_y,
		output coord_z, output paused, input ready);
	modport sink (input valid, input event_res, input coord_x, input coord_y,
		input coord_z, input paused, output ready);
endinterface

@@ hdl/ffcr_assembler.sv @@
// frame assembly: start detection, byte store, parity and end byte check
module ffcr_assembler import ffcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       perr_s1,
	output frame_t     frame
);

	logic [CountW-1:0] count_q;
	logic              in_frame_q;
	logic              frame_ok_q;
	logic [7:0]        store_q [StoreLen];
	logic              last;

	assign last = (count_q == CountW'(FrameLen - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			in_frame_q <= 1'b0;
			frame_ok_q <= 1'b1;
		end else if (valid_s1) begin
			if (!in_frame_q) begin
				// start byte parity is ignored
				if (byte_s1 == ByteStart) begin
					in_frame_q <= 1'b1;
					frame_ok_q <= 1'b1;
					count_q    <= '0;
				end
			end else if (last) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end else begin
				count_q    <= count_q + 1'b1;
				frame_ok_q <= frame_ok_q & ~perr_s1;
			end
		end
	end

	// end byte is checked on the fly and never stored
	always_ff @(posedge clk) begin
		if (valid_s1 && in_frame_q && !last) begin
			store_q[count_q] <= byte_s1;
		end
	end

	always_comb begin
		frame.done  = valid_s1 & in_frame_q & last;
		frame.ok    = frame_ok_q & ~perr_s1 & (byte_s1 == ByteEnd);
		frame.instr = store_q[0];
		frame.x     = {store_q[4], store_q[3], store_q[2], store_q[1]};
		frame.y     = {store_q[8], store_q[7], store_q[6], store_q[5]};
		frame.z     = {store_q[12], store_q[11], store_q[10], store_q[9]};
	end

endmodule

@@ hdl/ffcr_decoder.sv @@
// instruction decode and paused flag
module ffcr_decoder import ffcr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  frame_t  frame,
	output logic    res_valid,
	output result_t res
);

	logic paused_q;
	logic paused_next;

	always_comb begin
		paused_next = paused_q;
		res_valid   = 1'b0;
		res.ev      = EV_REJECT;
		res.x       = '0;
		res.y       = '0;
		res.z       = '0;
		if (frame.done) begin
			if (!frame.ok) begin
				res_valid = 1'b1;
			end else begin
				unique case (frame.instr)
					InstrWaypoint: begin
						res_valid = 1'b1;
						res.ev    = EV_WAYPOINT;
						res.x     = frame.x;
						res.y     = frame.y;
						res.z     = frame.z;
					end
					InstrStart: begin
						res_valid   = 1'b1;
						res.ev      = EV_START;
						paused_next = 1'b0;
					end
					InstrPause: begin
						res_valid   = 1'b1;
						res.ev      = EV_PAUSE;
						paused_next = 1'b1;
					end
					InstrStop: begin
						res_valid = 1'b1;
						res.ev    = EV_STOP;
					end
					InstrTelemetry: begin
						res_valid = 1'b1;
						res.ev    = EV_TELEMETRY;
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
		res.paused = paused_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b1;
		end else begin
			paused_q <= paused_next;
		end
	end

endmodule

@@ hdl/ffcr_out_buf.sv @@
// result register with one skid entry
module ffcr_out_buf import ffcr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t in_data,
	output logic    out_valid,
	output result_t out_data,
	input  logic    out_ready,
	output logic    skid_full
);

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    advance;

	assign advance = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= in_valid;
			end else begin
				out_valid_q  <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= in_data;
			end else begin
				out_q  <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign skid_full = skid_valid_q;

endmodule

@@ hdl/fixed_frame_command_receiver.sv @@
// a byte reaches its event through two register stages: s1 and the result register
// one byte per cycle while rx.ready is high; at most one event per 15 byte transfers
// rx.ready drops only while the skid entry of the event buffer is occupied
// reset: arst_n clears control state at once; idle, no frame open, paused flag set
// the frame byte store has no reset and is always fully written before use
module fixed_frame_command_receiver import ffcr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ffcr_byte_if.sink    rx,
	ffcr_event_if.source evt
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       perr_s1;

	frame_t  frame;
	logic    res_valid;
	result_t res;
	logic    out_valid;
	result_t out_data;
	logic    skid_full;

	// a result can only follow a frame of 15 byte transfers, so once the skid
	// entry fills, at most one more byte sits in s1 and it never makes a result
	assign rx.ready = ~skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rx.valid & rx.ready;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			perr_s1 <= rx.parity_error;
		end
	end

	// framing: count bytes, store them, judge the frame on its last byte
	ffcr_assembler u_assembler (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.perr_s1  (perr_s1),
		.frame    (frame)
	);

	// event selection and paused flag
	ffcr_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register plus skid entry, so s1 never stalls
	ffcr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (evt.ready),
		.skid_full (skid_full)
	);

	assign evt.valid     = out_valid;
	assign evt.event_res = out_data.ev;
	assign evt.coord_x   = out_data.x;
	assign evt.coord_y   = out_data.y;
	assign evt.coord_z   = out_data.z;
	assign evt.paused    = out_data.paused;

endmodule
